// ===== hw/rtl/rms_envelope_follower_core_macros.svh =====
// Assertion macros for the RMS envelope follower RTL.
// Included by the top level; depends on nothing else.
`ifndef RMS_ENVELOPE_FOLLOWER_CORE_MACROS_SVH
`define RMS_ENVELOPE_FOLLOWER_CORE_MACROS_SVH

`ifndef ASSERT_OFF
// Checks that a property holds at every clock edge outside reset.
`define RMSEF_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Checks that a condition is followed by a consequence in the next cycle.
`define RMSEF_ASSERT_NEXT(label, clk, rst_n, cond, nxt, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (nxt)) \
        else $error(msg);
`else
`define RMSEF_ASSERT(label, clk, rst_n, prop, msg)
`define RMSEF_ASSERT_NEXT(label, clk, rst_n, cond, nxt, msg)
`endif

`endif

// ===== hw/rtl/rmsef_pkg.sv =====
// Shared constants and types for the RMS envelope follower.
// No dependencies; imported by the top level.
`timescale 1ns / 1ps
`default_nettype none

package rmsef_pkg;

    // Reset value of the smoothing coefficient: 4 ms at 48 kHz in Q0.16.
    localparam int unsigned COEFF_RESET = 747;

    // Sequencer state vector and its codes.
    typedef logic [2:0] t_state;

    localparam t_state ST_IDLE = 3'd0;
    localparam t_state ST_DIFF = 3'd1;
    localparam t_state ST_MUL  = 3'd2;
    localparam t_state ST_UPD  = 3'd3;
    localparam t_state ST_SQRT = 3'd4;
    localparam t_state ST_DONE = 3'd5;

endpackage

`default_nettype wire

// ===== hw/rtl/rms_envelope_follower_core.sv =====
// RMS envelope follower: first-order mean-square averager with integer square root.
// Depends on rmsef_pkg and rms_envelope_follower_core_macros.svh.
`timescale 1ns / 1ps
`default_nettype none

`include "rms_envelope_follower_core_macros.svh"

// Each sample request updates the running mean square m = (1-a)*m + a*x*x, with a held in
// Q0.COEFF_FRAC_BITS, and returns floor(sqrt(floor(m))) as the envelope. An accepted request
// steps through the DIFF, MUL, UPD, SQRT and DONE states before its envelope reaches the
// result register, and the next sample is accepted only once the core is back in IDLE. The
// update runs through the bit-serial coefficient multiplier, which retires one coefficient bit
// per cycle, and the restoring square root, which produces one envelope bit per cycle.
// A finished envelope waits in its own output register, so a stalled consumer does not
// hold up the next sample until a second result is ready. The coefficient register should
// only be written while no sample is in flight.
module rms_envelope_follower_core #(
    parameter int SAMPLE_WIDTH    = 16,
    parameter int COEFF_FRAC_BITS = 16
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [COEFF_FRAC_BITS-1:0]        i_cfg_data,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic signed [SAMPLE_WIDTH-1:0]    i_sample,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic [SAMPLE_WIDTH-1:0]           o_envelope
);

    import rmsef_pkg::*;

    // Derived widths.
    localparam int SQW  = 2 * SAMPLE_WIDTH - 1;         // square of the magnitude
    localparam int MSW  = SQW + COEFF_FRAC_BITS;        // mean square
    localparam int AW   = MSW + 2;                      // signed product accumulator
    localparam int RW   = SAMPLE_WIDTH + 2;             // square root remainder
    localparam int RADW = 2 * SAMPLE_WIDTH;             // radicand shift register
    localparam int NMAX = (SAMPLE_WIDTH > COEFF_FRAC_BITS) ? SAMPLE_WIDTH : COEFF_FRAC_BITS;
    localparam int CW   = $clog2(NMAX);

    localparam logic [COEFF_FRAC_BITS-1:0] COEFF_RST = COEFF_FRAC_BITS'(COEFF_RESET);
    localparam logic [SAMPLE_WIDTH-1:0]    ENV_MAX   = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};
    localparam logic [CW-1:0]              MUL_LAST  = CW'(COEFF_FRAC_BITS - 1);
    localparam logic [CW-1:0]              SQRT_LAST = CW'(SAMPLE_WIDTH - 1);

    // Registers and their next values.
    t_state                       r_state,     n_state;
    logic [CW-1:0]                r_cnt,       n_cnt;
    logic [COEFF_FRAC_BITS-1:0]   r_coeff,     n_coeff;
    logic [COEFF_FRAC_BITS-1:0]   r_coef_sh,   n_coef_sh;
    logic [SQW-1:0]               r_sq,        n_sq;
    logic [MSW-1:0]               r_ms,        n_ms;
    logic signed [MSW:0]          r_diff,      n_diff;
    logic signed [AW-1:0]         r_acc,       n_acc;
    logic [RADW-1:0]              r_rad,       n_rad;
    logic [RW-1:0]                r_rem,       n_rem;
    logic [SAMPLE_WIDTH-1:0]      r_root,      n_root;
    logic [SAMPLE_WIDTH-1:0]      r_env,       n_env;
    logic                         r_out_valid, n_out_valid;

    // Datapath nets.
    logic [SAMPLE_WIDTH-1:0]      w_mag;
    logic [2*SAMPLE_WIDTH-1:0]    w_sq_full;
    logic signed [MSW:0]          w_diff;
    logic signed [AW-1:0]         w_addend;
    logic signed [AW-1:0]         w_acc_sum;
    logic [AW-1:0]                w_ms_sum;
    logic [RW+1:0]                w_rem_sh;
    logic [RW+1:0]                w_trial;
    logic [RW+1:0]                w_rem_sub;
    logic                         w_ge;

    // Magnitude and square of the incoming sample; full-scale negative gives 2^(W-1).
    assign w_mag     = i_sample[SAMPLE_WIDTH-1] ? $unsigned(~i_sample + 1'b1)
                                                : $unsigned(i_sample);
    assign w_sq_full = w_mag * w_mag;

    // Signed distance from the mean square to the scaled square: d = x*x*ONE - m.
    assign w_diff = $signed({1'b0, r_sq, {COEFF_FRAC_BITS{1'b0}}}) - $signed({1'b0, r_ms});

    // Shift-and-add step of a*d / ONE, one coefficient bit per cycle, flooring each shift.
    assign w_addend  = r_coef_sh[0] ? {{(AW-MSW-1){r_diff[MSW]}}, r_diff} : '0;
    assign w_acc_sum = r_acc + w_addend;

    // Updated mean square; the result never goes negative nor exceeds MSW bits.
    assign w_ms_sum = {2'b00, r_ms} + $unsigned(r_acc);

    // Restoring square root step: bring down two radicand bits and try (root*4 + 1).
    assign w_rem_sh  = {r_rem, r_rad[RADW-1 -: 2]};
    assign w_trial   = {2'b00, r_root, 2'b01};
    assign w_ge      = (w_rem_sh >= w_trial);
    assign w_rem_sub = w_rem_sh - w_trial;

    // Sequencer and next-state logic.
    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_coeff     = r_coeff;
        n_coef_sh   = r_coef_sh;
        n_sq        = r_sq;
        n_ms        = r_ms;
        n_diff      = r_diff;
        n_acc       = r_acc;
        n_rad       = r_rad;
        n_rem       = r_rem;
        n_root      = r_root;
        n_env       = r_env;
        n_out_valid = r_out_valid;

        if (i_cfg_we) begin
            n_coeff = i_cfg_data;
        end

        // The consumer takes the waiting result.
        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_sq      = w_sq_full[SQW-1:0];
                    n_coef_sh = r_coeff;
                    n_state   = ST_DIFF;
                end
            end
            ST_DIFF: begin
                n_diff  = w_diff;
                n_acc   = '0;
                n_cnt   = MUL_LAST;
                n_state = ST_MUL;
            end
            ST_MUL: begin
                n_acc     = w_acc_sum >>> 1;
                n_coef_sh = r_coef_sh >> 1;
                if (r_cnt == '0) begin
                    n_state = ST_UPD;
                end else begin
                    n_cnt = r_cnt - 1'b1;
                end
            end
            ST_UPD: begin
                n_ms    = w_ms_sum[MSW-1:0];
                n_rad   = {1'b0, w_ms_sum[MSW-1:COEFF_FRAC_BITS]};
                n_rem   = '0;
                n_root  = '0;
                n_cnt   = SQRT_LAST;
                n_state = ST_SQRT;
            end
            ST_SQRT: begin
                n_rad  = r_rad << 2;
                n_rem  = w_ge ? w_rem_sub[RW-1:0] : w_rem_sh[RW-1:0];
                n_root = {r_root[SAMPLE_WIDTH-2:0], w_ge};
                if (r_cnt == '0) begin
                    n_state = ST_DONE;
                end else begin
                    n_cnt = r_cnt - 1'b1;
                end
            end
            ST_DONE: begin
                // Load the output register once it is free or being emptied.
                if (!r_out_valid || !i_out_stall) begin
                    n_env       = r_root;
                    n_out_valid = 1'b1;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Control state and the running mean square.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_cnt       <= '0;
            r_coeff     <= COEFF_RST;
            r_ms        <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_coeff     <= n_coeff;
            r_ms        <= n_ms;
            r_out_valid <= n_out_valid;
        end
    end

    // Datapath registers need no reset.
    always_ff @(posedge i_clk) begin
        r_coef_sh <= n_coef_sh;
        r_sq      <= n_sq;
        r_diff    <= n_diff;
        r_acc     <= n_acc;
        r_rad     <= n_rad;
        r_rem     <= n_rem;
        r_root    <= n_root;
        r_env     <= n_env;
    end

    // Outputs.
    assign o_in_stall  = (r_state != ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_envelope  = r_env;

    // Assertions.
    `RMSEF_ASSERT_NEXT(a_accept_starts, i_clk, i_rst_n, i_in_valid && !o_in_stall, r_state == ST_DIFF, "accepted sample did not start the update")
    `RMSEF_ASSERT(a_result_from_done, i_clk, i_rst_n, $rose(o_out_valid) |-> ($past(r_state) == ST_DONE), "result appeared outside the completion step")
    `RMSEF_ASSERT(a_ms_no_overflow, i_clk, i_rst_n, (r_state == ST_UPD) |-> (w_ms_sum[AW-1:MSW] == '0), "mean square update overflowed")
    `RMSEF_ASSERT(a_env_in_range, i_clk, i_rst_n, o_out_valid |-> (o_envelope <= ENV_MAX), "envelope above full scale")

endmodule

`default_nettype wire

// ===== bench/rms_envelope_follower_core_tb.sv =====
// Self-checking bench for rms_envelope_follower_core: a scoreboard predicts each envelope.
// It depends on rmsef_pkg and the core RTL only.
`timescale 1ns / 1ps

module rms_envelope_follower_core_tb;
    import rmsef_pkg::COEFF_RESET;

    localparam int SW          = 16;
    localparam int CF          = 16;
    localparam int HOLD_CYCLES = 400;
    localparam int IDLE_LIMIT  = 3000;
    localparam int SETTLE      = 50;

    // Predicts the running mean square and holds the envelopes still owed by the core.
    class envelope_scoreboard;
        logic [CF-1:0]   coeff;
        logic [46:0]     mean_sq;
        logic [SW-1:0]   owed_env[$];
        int unsigned     mismatches;
        int unsigned     checked;
        int unsigned     samples;

        function new();
            coeff      = CF'(COEFF_RESET);
            mean_sq    = '0;
            mismatches = 0;
            checked    = 0;
            samples    = 0;
        endfunction

        function void set_coeff(logic [CF-1:0] value);
            coeff = value;
        endfunction

        // Bitwise floor square root, most significant result bit first.
        function logic [SW-1:0] floor_sqrt(longint unsigned v);
            longint unsigned root;
            longint unsigned trial;
            root = 0;
            for (int b = SW; b >= 0; b--) begin
                trial = root | (64'd1 << b);
                if (trial * trial <= v)
                    root = trial;
            end
            return root[SW-1:0];
        endfunction

        // Folds one accepted sample into the mean square and queues its envelope.
        function void note_sample(logic signed [SW-1:0] s);
            logic [SW-1:0]   raw;
            longint unsigned mag;
            longint unsigned keep;
            longint unsigned add;
            raw  = s;
            mag  = raw[SW-1] ? (64'd1 << SW) - raw : raw;
            keep = ((64'd1 << CF) - coeff) * mean_sq >> CF;
            add  = coeff * (mag * mag);
            mean_sq = 47'(keep + add);
            owed_env.push_back(floor_sqrt(mean_sq >> CF));
            samples++;
        endfunction

        task report(string what);
            $display("MISMATCH at %0t: %s", $realtime, what);
            mismatches++;
        endtask

        // Compares one accepted envelope with the oldest one owed.
        task check_envelope(logic [SW-1:0] env);
            logic [SW-1:0] want;
            if (owed_env.size() == 0) begin
                report($sformatf("envelope %0d arrived with none owed", env));
            end else begin
                want = owed_env.pop_front();
                checked++;
                if (env !== want)
                    report($sformatf("envelope %0d, predicted %0d", env, want));
            end
        endtask

        function int pending();
            return owed_env.size();
        endfunction
    endclass

    logic                 i_clk = 1'b0;
    logic                 i_rst_n;
    logic                 i_cfg_we;
    logic [CF-1:0]        i_cfg_data;
    logic                 i_in_valid;
    logic                 o_in_stall;
    logic signed [SW-1:0] i_sample;
    logic                 o_out_valid;
    logic                 i_out_stall;
    logic [SW-1:0]        o_envelope;

    envelope_scoreboard sb = new();
    bit   bench_live   = 1'b0;
    bit   no_idling    = 1'b0;
    bit   hold_wanted  = 1'b0;
    int   settings_run = 1;
    int   level;

    rms_envelope_follower_core #(
        .SAMPLE_WIDTH   (SW),
        .COEFF_FRAC_BITS(CF)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_sample   (i_sample),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_envelope (o_envelope)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Offers one sample request, sometimes after a random gap, and returns once it is taken.
    // The caller must follow at once with another request or with end_requests.
    task send_sample(logic signed [SW-1:0] s);
        if (!no_idling && $urandom_range(0, 3) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_sample   <= s;
        do @(posedge i_clk); while (o_in_stall);
        sb.note_sample(s);
    endtask

    task end_requests();
        i_in_valid <= 1'b0;
    endtask

    // Lets the core drain completely, then writes the coefficient.
    task write_coeff(logic [CF-1:0] value);
        end_requests();
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= value;
        @(posedge i_clk);
        sb.set_coeff(value);
        i_cfg_we   <= 1'b0;
        settings_run++;
    endtask

    // Draws a sample: uniform full-range values, small noise, extremes, or values around a level.
    function logic signed [SW-1:0] pick_sample();
        int v;
        case ($urandom_range(0, 9))
            0, 1, 2, 3: v = int'($urandom_range(0, 65535)) - 32768;
            4, 5:       v = int'($urandom_range(0, 64)) - 32;
            6: begin
                case ($urandom_range(0, 3))
                    0: v = 32767;
                    1: v = -32768;
                    2: v = 0;
                    default: v = -1;
                endcase
            end
            default: begin
                v = level + int'($urandom_range(0, 511)) - 256;
                if ($urandom_range(0, 1) == 1)
                    v = -v;
            end
        endcase
        if (v > 32767)
            v = 32767;
        if (v < -32768)
            v = -32768;
        return SW'(v);
    endfunction

    task random_phase(int count);
        level = int'($urandom_range(0, 32767));
        repeat (count) send_sample(pick_sample());
    endtask

    // Result side: checks each accepted envelope and stalls in random bursts or one long hold.
    initial begin
        i_out_stall = 1'b0;
        wait (bench_live);
        forever begin
            @(posedge i_clk);
            if (o_out_valid && !i_out_stall)
                sb.check_envelope(o_envelope);
            if (hold_wanted) begin
                hold_wanted = 1'b0;
                i_out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                i_out_stall <= 1'b0;
            end else if (!no_idling && $urandom_range(0, 5) == 0) begin
                i_out_stall <= 1'b1;
                repeat ($urandom_range(1, 19)) @(posedge i_clk);
                i_out_stall <= 1'b0;
            end
        end
    end

    // Watchdog: ends the run if no request, result or coefficient write is taken for too long.
    initial begin
        int quiet_cycles;
        quiet_cycles = 0;
        wait (bench_live);
        forever begin
            @(posedge i_clk);
            if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) || i_cfg_we)
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= IDLE_LIMIT) begin
                $display("watchdog: no progress for %0d cycles", IDLE_LIMIT);
                $display("end of test: mismatches");
                $finish;
            end
        end
    end

    // Main sequence: reset, directed samples, then random phases over several coefficients.
    initial begin
        i_rst_n    = 1'b0;
        i_cfg_we   = 1'b0;
        i_cfg_data = '0;
        i_in_valid = 1'b0;
        i_sample   = '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        bench_live = 1'b1;

        // Reset coefficient: silence, both full-scale ends, smallest magnitudes, bit patterns.
        send_sample(16'sd0);
        send_sample(16'sd32767);
        send_sample(-16'sd32768);
        send_sample(-16'sd1);
        send_sample(16'sd1);
        send_sample(16'sh5555);
        send_sample(16'shAAAA);
        repeat (3) send_sample(16'sd32767);
        send_sample(-16'sd32768);

        // Largest coefficient: the mean square almost follows the squared sample.
        write_coeff(16'hFFFF);
        repeat (3) send_sample(-16'sd32768);
        send_sample(16'sd0);
        send_sample(16'sd32767);
        send_sample(-16'sd2);

        // Zero coefficient: the envelope must hold whatever the input does.
        write_coeff(16'h0000);
        send_sample(16'sd12345);
        send_sample(-16'sd32768);
        send_sample(16'sd0);
        send_sample(16'sd32767);

        // Random phases; the first at the reset coefficient.
        write_coeff(16'(COEFF_RESET));
        random_phase(150);
        write_coeff(16'hFFFF);
        random_phase(80);
        hold_wanted = 1'b1;
        random_phase(80);
        write_coeff(16'h0001);
        random_phase(150);
        write_coeff(16'($urandom_range(2, 65534)));
        random_phase(150);
        write_coeff(16'h0000);
        random_phase(120);
        write_coeff(16'h8000);
        random_phase(150);
        write_coeff(16'($urandom_range(0, 65535)));
        random_phase(150);

        // Closing stretch without any idling on either side.
        write_coeff(16'(COEFF_RESET));
        no_idling = 1'b1;
        random_phase(150);
        end_requests();

        while (sb.pending() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);

        $display("covered %0d samples over %0d coefficient settings, %0d envelopes checked",
                 sb.samples, settings_run, sb.checked);
        $display("including both full-scale ends, zero and largest coefficients, long hold");
        if (sb.mismatches == 0) begin
            $display("end of test: clean");
        end else begin
            $display("%0d mismatches found", sb.mismatches);
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+hw/rtl
hw/rtl/rmsef_pkg.sv
hw/rtl/rms_envelope_follower_core.sv
bench/rms_envelope_follower_core_tb.sv
